[hdl/voxel_cube_diagonal_wave_assert.svh]
// assertion macros for the voxel cube wave block
// all of them sample on clk and are held off while rst is high
`ifndef VOXEL_CUBE_DIAGONAL_WAVE_ASSERT_SVH
`define VOXEL_CUBE_DIAGONAL_WAVE_ASSERT_SVH

// condition holds at every edge
`define VCDW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define VCDW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define VCDW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/vcdw_pkg.sv]
`timescale 1ns / 1ps

package vcdw_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_FLUSH,
    ST_READ,
    ST_DONE
  } state_t;

  // colour phases
  localparam logic [1:0] PH_BLUE_GREEN = 2'd0;
  localparam logic [1:0] PH_GREEN_RED  = 2'd1;
  localparam logic [1:0] PH_RED_BLUE   = 2'd2;

endpackage

[hdl/vcdw_if.sv]
`timescale 1ns / 1ps

interface vcdw_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [2:0] voxel_x;
  logic [2:0] voxel_y;
  logic [2:0] voxel_z;

  modport source (output valid, req_type, voxel_x, voxel_y, voxel_z, input ready);
  modport sink   (input valid, req_type, voxel_x, voxel_y, voxel_z, output ready);
endinterface

interface vcdw_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [4:0] front_position;
  logic [1:0] colour_phase;

  modport source (output valid, red, green, blue, front_position, colour_phase,
                  input ready);
  modport sink   (input valid, red, green, blue, front_position, colour_phase,
                  output ready);
endinterface

[hdl/vcdw_ram.sv]
`timescale 1ns / 1ps

module vcdw_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/vcdw_shade.sv]
`timescale 1ns / 1ps

module vcdw_shade #(
  parameter int AW          = 9,
  parameter int FRONT_LIMIT = 21
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               issue,
  input  logic [AW-1:0]                      issue_addr,
  input  logic [$clog2(FRONT_LIMIT+1)-1:0]   diag,
  input  logic [$clog2(FRONT_LIMIT+1)-1:0]   front,
  input  logic [1:0]                         phase,
  input  vcdw_pkg::rgb_t                     rdata,
  output logic                               we,
  output logic [AW-1:0]                      waddr,
  output vcdw_pkg::rgb_t                     wdata
);

  localparam int FW = $clog2(FRONT_LIMIT + 1);

  // floor(9v/10) as one constant multiply: 9 * 52429 / 2^19
  function automatic logic [7:0] dim9(input logic [7:0] v);
    logic [27:0] p;
    p = 28'(v) * 28'd471861;
    return 8'(p >> 19);
  endfunction

  // floor(x/3), exact for every 9-bit x
  function automatic logic [7:0] div3(input logic [8:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'd43691;
    return 8'(p >> 17);
  endfunction

  function automatic logic [7:0] weigh(input logic [7:0] v, input logic [1:0] ad);
    logic [7:0] w;
    case (ad)
      2'd0:    w = v;
      2'd1:    w = div3({v, 1'b0});
      2'd2:    w = div3({1'b0, v});
      default: w = 8'd0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hff : s[7:0];
  endfunction

  // ramp values per distance, fixed at elaboration
  logic [7:0] up_tab [FRONT_LIMIT+1];
  logic [7:0] dn_tab [FRONT_LIMIT+1];

  for (genvar k = 0; k <= FRONT_LIMIT; k++) begin : g_ramp
    localparam int Up = (k * 255) / FRONT_LIMIT;
    localparam int Dn = ((FRONT_LIMIT - k) * 255) / FRONT_LIMIT;
    assign up_tab[k] = 8'(Up);
    assign dn_tab[k] = 8'(Dn);
  end

  logic [FW-1:0]  ad_full;
  logic           near;
  logic [1:0]     ad;
  logic [7:0]     up_v;
  logic [7:0]     dn_v;
  vcdw_pkg::rgb_t base;
  vcdw_pkg::rgb_t add;

  always_comb begin
    ad_full = (front >= diag) ? front - diag : diag - front;
    near    = (ad_full <= FW'(2));
    ad      = ad_full[1:0];
    up_v    = up_tab[diag];
    dn_v    = dn_tab[diag];
    unique case (phase)
      vcdw_pkg::PH_BLUE_GREEN: base = '{red: 8'd0, green: up_v, blue: dn_v};
      vcdw_pkg::PH_GREEN_RED:  base = '{red: up_v, green: dn_v, blue: 8'd0};
      vcdw_pkg::PH_RED_BLUE:   base = '{red: dn_v, green: 8'd0, blue: up_v};
      default:                 base = '0;
    endcase
    if (near) begin
      add = '{red: weigh(base.red, ad), green: weigh(base.green, ad),
              blue: weigh(base.blue, ad)};
    end else begin
      add = '0;
    end
  end

  // stage a: colour for the voxel whose read is in flight
  logic           valid_a;
  logic [AW-1:0]  addr_a;
  vcdw_pkg::rgb_t add_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= issue;
    end
  end

  always_ff @(posedge clk) begin
    addr_a <= issue_addr;
    add_a  <= add;
  end

  // stage b: dim the stored voxel and add the wave colour
  always_comb begin
    we    = valid_a;
    waddr = addr_a;
    wdata = '{red:   sat_add(dim9(rdata.red),   add_a.red),
              green: sat_add(dim9(rdata.green), add_a.green),
              blue:  sat_add(dim9(rdata.blue),  add_a.blue)};
  end

endmodule

[hdl/voxel_cube_diagonal_wave.sv]
`timescale 1ns / 1ps
// read request: the ram read is issued when it is taken, pend holds the voxel from ST_READ,
//   and ST_DONE loads the output register once the result slot is free
// frame request: the sweep updates one voxel per cycle, then ST_FLUSH steps the front
// one request in work at a time; a new request is taken while a result waits
// reset: synchronous; a clearing pass over all CUBE_SIDE**3 voxels zeroes the voxel ram,
//   no request is taken until it ends

`include "voxel_cube_diagonal_wave_assert.svh"

module voxel_cube_diagonal_wave #(
  parameter int CUBE_SIDE = 8
) (
  input logic        clk,
  input logic        rst,
  vcdw_req_if.sink   req,
  vcdw_res_if.source res
);

  localparam int FRONT_LIMIT = 3 * (CUBE_SIDE - 1);
  localparam int FW          = $clog2(FRONT_LIMIT + 1);
  localparam int VOX_N       = CUBE_SIDE * CUBE_SIDE * CUBE_SIDE;
  localparam int AW          = $clog2(VOX_N);
  localparam int CW          = $clog2(CUBE_SIDE);

  vcdw_pkg::state_t state, state_next;

  logic [AW-1:0]  cnt;
  logic [CW-1:0]  cx, cy, cz;
  logic [FW-1:0]  front;
  logic [1:0]     phase;
  logic           in_range;
  vcdw_pkg::rgb_t pend;

  logic           out_valid;
  vcdw_pkg::rgb_t out_rgb;
  logic [4:0]     out_front;
  logic [1:0]     out_phase;

  logic           req_fire;
  logic           cnt_last;
  logic           slot_free;
  logic           load_out;
  logic [AW-1:0]  rd_addr;
  logic           rd_in_range;
  logic [FW-1:0]  diag;

  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  vcdw_pkg::rgb_t ram_wdata;
  vcdw_pkg::rgb_t ram_rdata;

  logic           sh_issue;
  logic           sh_we;
  logic [AW-1:0]  sh_waddr;
  vcdw_pkg::rgb_t sh_wdata;

  assign req_fire    = req.valid && req.ready;
  assign cnt_last    = (cnt == AW'(VOX_N - 1));
  assign slot_free   = !out_valid || res.ready;
  assign diag        = FW'(cx) + FW'(cy) + FW'(cz);
  assign rd_in_range = (int'(req.voxel_x) < CUBE_SIDE) && (int'(req.voxel_y) < CUBE_SIDE) &&
                       (int'(req.voxel_z) < CUBE_SIDE);
  assign rd_addr     = AW'((int'(req.voxel_x) * CUBE_SIDE + int'(req.voxel_y)) * CUBE_SIDE +
                           int'(req.voxel_z));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      vcdw_pkg::ST_CLEAR: if (cnt_last) state_next = vcdw_pkg::ST_IDLE;
      vcdw_pkg::ST_IDLE: begin
        if (req_fire) begin
          state_next = req.req_type ? vcdw_pkg::ST_READ : vcdw_pkg::ST_SWEEP;
        end
      end
      vcdw_pkg::ST_SWEEP: if (cnt_last) state_next = vcdw_pkg::ST_FLUSH;
      vcdw_pkg::ST_FLUSH: state_next = vcdw_pkg::ST_DONE;
      vcdw_pkg::ST_READ:  state_next = vcdw_pkg::ST_DONE;
      vcdw_pkg::ST_DONE:  if (slot_free) state_next = vcdw_pkg::ST_IDLE;
      default:            state_next = vcdw_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready = (state == vcdw_pkg::ST_IDLE);
    sh_issue  = (state == vcdw_pkg::ST_SWEEP);
    load_out  = (state == vcdw_pkg::ST_DONE) && slot_free;
    if (state == vcdw_pkg::ST_SWEEP) begin
      ram_re    = 1'b1;
      ram_raddr = cnt;
    end else begin
      ram_re    = req_fire && req.req_type && rd_in_range;
      ram_raddr = rd_addr;
    end
    if (state == vcdw_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = sh_we;
      ram_waddr = sh_waddr;
      ram_wdata = sh_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vcdw_pkg::ST_CLEAR;
      cnt   <= '0;
      cx    <= '0;
      cy    <= '0;
      cz    <= '0;
      front <= '0;
      phase <= vcdw_pkg::PH_BLUE_GREEN;
    end else begin
      state <= state_next;
      if (state == vcdw_pkg::ST_CLEAR || state == vcdw_pkg::ST_SWEEP) begin
        cnt <= cnt_last ? '0 : cnt + AW'(1);
      end
      if (state == vcdw_pkg::ST_SWEEP) begin
        // z fastest, matching the ram address order
        if (cz == CW'(CUBE_SIDE - 1)) begin
          cz <= '0;
          if (cy == CW'(CUBE_SIDE - 1)) begin
            cy <= '0;
            cx <= (cx == CW'(CUBE_SIDE - 1)) ? '0 : cx + CW'(1);
          end else begin
            cy <= cy + CW'(1);
          end
        end else begin
          cz <= cz + CW'(1);
        end
      end
      if (state == vcdw_pkg::ST_FLUSH) begin
        if (front == FW'(FRONT_LIMIT)) begin
          front <= '0;
          phase <= (phase == vcdw_pkg::PH_RED_BLUE) ? vcdw_pkg::PH_BLUE_GREEN
                                                    : phase + 2'd1;
        end else begin
          front <= front + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      in_range <= rd_in_range;
    end
    if (state == vcdw_pkg::ST_READ) begin
      pend <= in_range ? ram_rdata : '0;
    end else if (state == vcdw_pkg::ST_FLUSH) begin
      pend <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rgb   <= pend;
      out_front <= 5'(front);
      out_phase <= phase;
    end
  end

  assign res.valid          = out_valid;
  assign res.red            = out_rgb.red;
  assign res.green          = out_rgb.green;
  assign res.blue           = out_rgb.blue;
  assign res.front_position = out_front;
  assign res.colour_phase   = out_phase;

  vcdw_ram #(
    .DEPTH (VOX_N),
    .WIDTH ($bits(vcdw_pkg::rgb_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vcdw_shade #(
    .AW          (AW),
    .FRONT_LIMIT (FRONT_LIMIT)
  ) u_shade (
    .clk        (clk),
    .rst        (rst),
    .issue      (sh_issue),
    .issue_addr (cnt),
    .diag       (diag),
    .front      (front),
    .phase      (phase),
    .rdata      (ram_rdata),
    .we         (sh_we),
    .waddr      (sh_waddr),
    .wdata      (sh_wdata)
  );

  // write-back must never hit the entry being fetched in the same cycle
  `VCDW_ASSERT_NOW(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr, "ram clash")
  `VCDW_ASSERT_NEXT(a_front_moves, state == vcdw_pkg::ST_FLUSH, front != $past(front), "front stuck")
  `VCDW_ASSERT_ALWAYS(a_front_range, front <= FW'(FRONT_LIMIT), "front out of range")
  `VCDW_ASSERT_ALWAYS(a_phase_range, phase <= vcdw_pkg::PH_RED_BLUE, "phase out of range")
  `VCDW_ASSERT_NOW(a_res_from_done, $rose(out_valid), $past(state) == vcdw_pkg::ST_DONE, "stray")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int SIDE        = 8;
  localparam int VOXELS      = SIDE * SIDE * SIDE;
  localparam int FRONT_MAX   = 3 * (SIDE - 1);
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_WAIT  = 600;
  localparam int RAND_ITEMS  = 1150;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    vcdw_pkg::rgb_t rgb;
    logic [4:0]     front;
    logic [1:0]     phase;
  } wave_res_t;

  typedef struct {
    logic       rt;
    logic [2:0] x;
    logic [2:0] y;
    logic [2:0] z;
    bit         typed;
    wave_res_t  lit;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  vcdw_req_if req_ch ();
  vcdw_res_if res_ch ();

  voxel_cube_diagonal_wave #(.CUBE_SIDE(SIDE)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the cube and the wave
  vcdw_pkg::rgb_t voxel_mem [VOXELS];
  int unsigned    wave_front;
  logic [1:0]     wave_phase;

  wave_res_t   pending_results [$];
  dir_row_t    directed_rows [$];

  int src_idle_pct;
  int snk_idle_pct;
  int mismatches;
  int results_seen;
  int cycle_count;
  int frames_sent;
  int reads_sent;
  int lit_reads;
  int phase_wraps;
  int saturations;

  function automatic logic [7:0] dim_level(logic [7:0] v);
    return 8'((int'(v) * 9) / 10);
  endfunction

  function automatic logic [7:0] add_sat(logic [7:0] a, int unsigned b);
    int unsigned s;
    s = a + b;
    if (s > 255) begin
      saturations++;
      return 8'd255;
    end
    return s[7:0];
  endfunction

  function automatic int blend(int s, int e, int diag);
    int num;
    if (e >= s) num = s * FRONT_MAX + diag * (e - s);
    else num = s * FRONT_MAX - diag * (s - e);
    return num / FRONT_MAX;
  endfunction

  function automatic vcdw_pkg::rgb_t wave_start(logic [1:0] ph);
    case (ph)
      vcdw_pkg::PH_BLUE_GREEN: return '{8'd0, 8'd0, 8'd255};
      vcdw_pkg::PH_GREEN_RED:  return '{8'd0, 8'd255, 8'd0};
      default:                 return '{8'd255, 8'd0, 8'd0};
    endcase
  endfunction

  function automatic vcdw_pkg::rgb_t wave_end(logic [1:0] ph);
    case (ph)
      vcdw_pkg::PH_BLUE_GREEN: return '{8'd0, 8'd255, 8'd0};
      vcdw_pkg::PH_GREEN_RED:  return '{8'd255, 8'd0, 8'd0};
      default:                 return '{8'd0, 8'd0, 8'd255};
    endcase
  endfunction

  function automatic void step_wave();
    vcdw_pkg::rgb_t c0;
    vcdw_pkg::rgb_t c1;
    int unsigned    diag;
    int unsigned    ad;
    int unsigned    idx;
    for (int i = 0; i < VOXELS; i++) begin
      voxel_mem[i].red   = dim_level(voxel_mem[i].red);
      voxel_mem[i].green = dim_level(voxel_mem[i].green);
      voxel_mem[i].blue  = dim_level(voxel_mem[i].blue);
    end
    c0 = wave_start(wave_phase);
    c1 = wave_end(wave_phase);
    for (int x = 0; x < SIDE; x++) begin
      for (int y = 0; y < SIDE; y++) begin
        for (int z = 0; z < SIDE; z++) begin
          diag = x + y + z;
          ad = (wave_front >= diag) ? wave_front - diag : diag - wave_front;
          if (ad <= 2) begin
            idx = (x * SIDE + y) * SIDE + z;
            voxel_mem[idx].red = add_sat(voxel_mem[idx].red,
                                         blend(c0.red, c1.red, diag) * (3 - ad) / 3);
            voxel_mem[idx].green = add_sat(voxel_mem[idx].green,
                                           blend(c0.green, c1.green, diag) * (3 - ad) / 3);
            voxel_mem[idx].blue = add_sat(voxel_mem[idx].blue,
                                          blend(c0.blue, c1.blue, diag) * (3 - ad) / 3);
          end
        end
      end
    end
    wave_front++;
    if (wave_front > FRONT_MAX) begin
      wave_front = 0;
      wave_phase = (wave_phase == vcdw_pkg::PH_RED_BLUE) ? vcdw_pkg::PH_BLUE_GREEN
                                                         : wave_phase + 2'd1;
      phase_wraps++;
    end
  endfunction

  function automatic wave_res_t predict_request(logic rt, logic [2:0] x, logic [2:0] y,
                                                logic [2:0] z);
    wave_res_t r;
    r.rgb = '0;
    if (rt == REQ_FRAME) begin
      step_wave();
      frames_sent++;
    end else begin
      r.rgb = voxel_mem[(int'(x) * SIDE + int'(y)) * SIDE + int'(z)];
      reads_sent++;
      if (r.rgb != '0) lit_reads++;
    end
    r.front = wave_front[4:0];
    r.phase = wave_phase;
    return r;
  endfunction

  function automatic wave_res_t mk_res(int r, int g, int b, int f, int p);
    wave_res_t w;
    w.rgb   = '{8'(r), 8'(g), 8'(b)};
    w.front = 5'(f);
    w.phase = 2'(p);
    return w;
  endfunction

  task automatic add_row(logic rt, int x, int y, int z, bit typed, wave_res_t lit);
    dir_row_t row;
    row.rt    = rt;
    row.x     = 3'(x);
    row.y     = 3'(y);
    row.z     = 3'(z);
    row.typed = typed;
    row.lit   = lit;
    directed_rows.push_back(row);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
    mismatches++;
  endtask

  task automatic send_request(logic rt, logic [2:0] x, logic [2:0] y, logic [2:0] z,
                              bit typed, wave_res_t lit);
    wave_res_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.voxel_x  <= x;
    req_ch.voxel_y  <= y;
    req_ch.voxel_z  <= z;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pred = predict_request(rt, x, y, z);
    pending_results.push_back(typed ? lit : pred);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_requests(int count);
    logic rt;
    for (int i = 0; i < count; i++) begin
      rt = ($urandom_range(0, 99) < 30) ? REQ_FRAME : REQ_READ;
      send_request(rt, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)), 1'b0, '0);
    end
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    wave_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", res_ch.front_position, -1);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.red !== want.rgb.red)
          report_mismatch("red", res_ch.red, want.rgb.red);
        if (res_ch.green !== want.rgb.green)
          report_mismatch("green", res_ch.green, want.rgb.green);
        if (res_ch.blue !== want.rgb.blue)
          report_mismatch("blue", res_ch.blue, want.rgb.blue);
        if (res_ch.front_position !== want.front)
          report_mismatch("front_position", res_ch.front_position, want.front);
        if (res_ch.colour_phase !== want.phase)
          report_mismatch("colour_phase", res_ch.colour_phase, want.phase);
      end
      results_seen++;
    end
  end

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_READ;
    req_ch.voxel_x  = 3'd0;
    req_ch.voxel_y  = 3'd0;
    req_ch.voxel_z  = 3'd0;
    res_ch.ready    = 1'b0;
    src_idle_pct    = 28;
    snk_idle_pct    = 58;
    mismatches      = 0;
    results_seen    = 0;
    cycle_count     = 0;
    frames_sent     = 0;
    reads_sent      = 0;
    lit_reads       = 0;
    phase_wraps     = 0;
    saturations     = 0;
    wave_front      = 0;
    wave_phase      = vcdw_pkg::PH_BLUE_GREEN;
    foreach (voxel_mem[i]) voxel_mem[i] = '0;

    // cleared cube reads black at each voxel read here
    add_row(REQ_READ, 0, 0, 0, 1'b1, mk_res(0, 0, 0, 0, 0));
    add_row(REQ_READ, 7, 7, 7, 1'b1, mk_res(0, 0, 0, 0, 0));
    add_row(REQ_READ, 7, 0, 5, 1'b1, mk_res(0, 0, 0, 0, 0));
    // frame ignores its coordinates and returns no colour
    add_row(REQ_FRAME, 7, 7, 7, 1'b1, mk_res(0, 0, 0, 1, 0));
    // corner sat right on the front gets full blue
    add_row(REQ_READ, 0, 0, 0, 1'b1, mk_res(0, 0, 255, 1, 0));
    add_row(REQ_READ, 1, 0, 0, 1'b0, '0);
    add_row(REQ_READ, 1, 1, 0, 1'b0, '0);
    add_row(REQ_READ, 0, 3, 0, 1'b1, mk_res(0, 0, 0, 1, 0));
    add_row(REQ_READ, 7, 7, 7, 1'b1, mk_res(0, 0, 0, 1, 0));
    add_row(REQ_FRAME, 0, 0, 0, 1'b1, mk_res(0, 0, 0, 2, 0));
    add_row(REQ_FRAME, 5, 2, 6, 1'b1, mk_res(0, 0, 0, 3, 0));
    add_row(REQ_READ, 0, 0, 0, 1'b0, '0);
    add_row(REQ_READ, 2, 1, 0, 1'b0, '0);
    add_row(REQ_READ, 0, 0, 3, 1'b0, '0);
    add_row(REQ_READ, 1, 2, 2, 1'b0, '0);
    add_row(REQ_READ, 0, 0, 7, 1'b1, mk_res(0, 0, 0, 3, 0));
    add_row(REQ_FRAME, 3, 3, 3, 1'b0, '0);
    add_row(REQ_READ, 4, 0, 0, 1'b0, '0);
    add_row(REQ_READ, 7, 6, 7, 1'b1, mk_res(0, 0, 0, 4, 0));
    add_row(REQ_READ, 6, 5, 4, 1'b1, mk_res(0, 0, 0, 4, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].rt, directed_rows[i].x, directed_rows[i].y,
                   directed_rows[i].z, directed_rows[i].typed, directed_rows[i].lit);

    random_requests(RAND_ITEMS / 3);
    // hold the sender until the block is fully drained
    req_ch.valid <= 1'b0;
    wait_drained();

    src_idle_pct = 58;
    snk_idle_pct = 28;
    random_requests(RAND_ITEMS / 3);
    req_ch.valid <= 1'b0;
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_requests(RAND_ITEMS - 2 * (RAND_ITEMS / 3));
    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d frame steps and %0d voxel reads (%0d non-black), %0d results",
             frames_sent, reads_sent, lit_reads, results_seen);
    $display("wave wrapped its colour phase %0d times, %0d channel additions saturated",
             phase_wraps, saturations);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
